FILE: rtl/core/lsafg_pkg.sv
// lsafg_pkg: shared types and constants of the led strip animation frame generator
// used by every module under rtl/core; depends on nothing
`default_nettype none

package lsafg_pkg;

    localparam int NUM_LEDS_DEF  = 33;
    localparam int TRAIL_LEN_DEF = 10;

    localparam int PIX_W   = 6;
    localparam int COLOR_W = 24;
    localparam int HOLD_W  = 9;
    localparam int MODE_W  = 4;
    localparam int K_W     = 17;

    typedef enum logic [MODE_W-1:0] {
        MODE_DARK    = 4'd0,
        MODE_RAINBOW = 4'd1,
        MODE_BREATHE = 4'd2,
        MODE_WAVE    = 4'd3,
        MODE_TRAILS  = 4'd4,
        MODE_ALARM   = 4'd5,
        MODE_GREEN   = 4'd6,
        MODE_RED     = 4'd7,
        MODE_BLUE    = 4'd8
    } t_mode;

    typedef enum logic {
        CFG_MODE          = 1'b0,
        CFG_BREATHE_COLOR = 1'b1
    } t_cfg_index;

    localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00ff00;
    localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hff0000;
    localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h0000ff;

    localparam logic [HOLD_W-1:0] HOLD_RAINBOW    = 9'd100;
    localparam logic [HOLD_W-1:0] HOLD_BREATHE    = 9'd30;
    localparam logic [HOLD_W-1:0] HOLD_WAVE       = 9'd80;
    localparam logic [HOLD_W-1:0] HOLD_TRAILS     = 9'd30;
    localparam logic [HOLD_W-1:0] HOLD_ALARM_LONG = 9'd400;
    localparam logic [HOLD_W-1:0] HOLD_ALARM      = 9'd200;

    typedef struct packed {
        t_mode               mode;
        logic [COLOR_W-1:0]  color;
        logic [K_W-1:0]      breathe_k;
        logic [7:0]          rainbow_offset;
        logic [PIX_W-1:0]    head_cw;
        logic [PIX_W-1:0]    head_ccw;
        logic [PIX_W-1:0]    wave_step;
        logic [1:0]          alarm_phase;
        logic [HOLD_W-1:0]   hold;
    } t_frame_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/lsafg_front.sv
// lsafg_front: accepts frame requests, holds configuration and animation state
// builds one frame command per request; depends on lsafg_pkg
`default_nettype none

module lsafg_front #(
    parameter int NUM_LEDS = lsafg_pkg::NUM_LEDS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_advance,
    output logic                              o_stall,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [lsafg_pkg::COLOR_W-1:0] i_cfg_data,
    output logic                              o_push,
    output lsafg_pkg::t_frame_cmd             o_cmd,
    input  wire logic                         i_full
);

    localparam int PW = lsafg_pkg::PIX_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(NUM_LEDS - 1);
    localparam logic [PW-1:0] HALF_IDX = PW'(NUM_LEDS / 2);

    typedef logic [lsafg_pkg::K_W-1:0] t_k_lut [51];

    // ceil(lvl * 2^16 / 50): colour * k >> 16 equals colour * lvl / 50 truncated
    function automatic t_k_lut f_k_lut();
        t_k_lut lut;
        for (int l = 0; l < 51; l++) begin
            lut[l] = lsafg_pkg::K_W'((l * 65536 + 49) / 50);
        end
        return lut;
    endfunction

    localparam t_k_lut BREATHE_K = f_k_lut();

    lsafg_pkg::t_mode             r_mode;
    logic [lsafg_pkg::COLOR_W-1:0] r_color;
    logic [7:0]                   r_offset, n_offset;
    logic [PW-1:0]                r_head_cw, n_head_cw;
    logic [PW-1:0]                r_head_ccw, n_head_ccw;
    logic [PW-1:0]                r_wave_step, n_wave_step;
    logic [5:0]                   r_level, n_level;
    logic                         r_rising, n_rising;
    logic [1:0]                   r_alarm, n_alarm;

    logic                         accept;
    logic [5:0]                   level_c;
    logic [5:0]                   level_t;
    logic [lsafg_pkg::HOLD_W-1:0] hold;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign level_c = (r_level > 6'd50) ? 6'd50 : r_level;

    always_comb begin
        unique case (r_mode)
            lsafg_pkg::MODE_RAINBOW: hold = lsafg_pkg::HOLD_RAINBOW;
            lsafg_pkg::MODE_BREATHE: hold = lsafg_pkg::HOLD_BREATHE;
            lsafg_pkg::MODE_WAVE:    hold = lsafg_pkg::HOLD_WAVE;
            lsafg_pkg::MODE_TRAILS:  hold = lsafg_pkg::HOLD_TRAILS;
            lsafg_pkg::MODE_ALARM:   hold = (r_alarm == 2'd0) ? lsafg_pkg::HOLD_ALARM_LONG
                                                              : lsafg_pkg::HOLD_ALARM;
            default:                 hold = '0;
        endcase
    end

    always_comb begin
        o_cmd.mode           = r_mode;
        o_cmd.color          = r_color;
        o_cmd.breathe_k      = BREATHE_K[level_c];
        o_cmd.rainbow_offset = r_offset;
        o_cmd.head_cw        = r_head_cw;
        o_cmd.head_ccw       = r_head_ccw;
        o_cmd.wave_step      = r_wave_step;
        o_cmd.alarm_phase    = r_alarm;
        o_cmd.hold           = hold;
    end

    always_comb begin
        n_offset    = r_offset;
        n_head_cw   = r_head_cw;
        n_head_ccw  = r_head_ccw;
        n_wave_step = r_wave_step;
        n_level     = r_level;
        n_rising    = r_rising;
        n_alarm     = r_alarm;
        level_t     = level_c;
        if (accept && i_advance) begin
            unique case (r_mode)
                lsafg_pkg::MODE_RAINBOW: begin
                    n_offset = r_offset + 8'd5;
                end
                lsafg_pkg::MODE_BREATHE: begin
                    if (r_rising) begin
                        level_t = level_c + 6'd1;
                    end else begin
                        level_t = (level_c > 6'd0) ? level_c - 6'd1 : 6'd0;
                    end
                    if (level_t >= 6'd50) begin
                        level_t  = 6'd50;
                        n_rising = 1'b0;
                    end
                    if (level_t <= 6'd5) begin
                        level_t  = 6'd5;
                        n_rising = 1'b1;
                    end
                    n_level = level_t;
                end
                lsafg_pkg::MODE_WAVE: begin
                    n_wave_step = (r_wave_step == LAST_IDX) ? '0 : r_wave_step + PW'(1);
                end
                lsafg_pkg::MODE_TRAILS: begin
                    n_head_cw  = (r_head_cw == LAST_IDX) ? '0 : r_head_cw + PW'(1);
                    n_head_ccw = (r_head_ccw == '0) ? LAST_IDX : r_head_ccw - PW'(1);
                end
                lsafg_pkg::MODE_ALARM: begin
                    n_alarm = r_alarm + 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= lsafg_pkg::MODE_RAINBOW;
            r_color     <= lsafg_pkg::COLOR_RED;
            r_offset    <= '0;
            r_head_cw   <= '0;
            r_head_ccw  <= HALF_IDX;
            r_wave_step <= '0;
            r_level     <= '0;
            r_rising    <= 1'b1;
            r_alarm     <= '0;
        end else if (i_cfg_we && i_cfg_index == lsafg_pkg::CFG_MODE) begin
            r_mode     <= lsafg_pkg::t_mode'(i_cfg_data[lsafg_pkg::MODE_W-1:0]);
            r_offset   <= '0;
            r_head_cw  <= '0;
            r_head_ccw <= HALF_IDX;
            r_alarm    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == lsafg_pkg::CFG_BREATHE_COLOR) begin
                r_color <= i_cfg_data;
            end
            r_offset    <= n_offset;
            r_head_cw   <= n_head_cw;
            r_head_ccw  <= n_head_ccw;
            r_wave_step <= n_wave_step;
            r_level     <= n_level;
            r_rising    <= n_rising;
            r_alarm     <= n_alarm;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lsafg_cmd_queue.sv
// lsafg_cmd_queue: two-entry queue of frame commands between front and back
// depends on lsafg_pkg
`default_nettype none

module lsafg_cmd_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  lsafg_pkg::t_frame_cmd      i_cmd,
    output logic                       o_full,
    output logic                       o_valid,
    output lsafg_pkg::t_frame_cmd      o_cmd,
    input  wire logic                  i_pop
);

    lsafg_pkg::t_frame_cmd r_mem [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lsafg_back.sv
// lsafg_back: walks the strip for each frame command, one pixel per cycle while i_stall is low
// two pipeline stages, the second is the output register; depends on lsafg_pkg
`default_nettype none

module lsafg_back #(
    parameter int NUM_LEDS  = lsafg_pkg::NUM_LEDS_DEF,
    parameter int TRAIL_LEN = lsafg_pkg::TRAIL_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  lsafg_pkg::t_frame_cmd              i_cmd,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [lsafg_pkg::PIX_W-1:0]        o_pixel_index,
    output logic [lsafg_pkg::COLOR_W-1:0]      o_pixel_color,
    output logic                               o_frame_last,
    output logic [lsafg_pkg::HOLD_W-1:0]       o_hold_ms
);

    localparam int PW = lsafg_pkg::PIX_W;
    localparam int PRW = lsafg_pkg::K_W + 8;
    localparam logic [PW:0]   N7       = (PW + 1)'(NUM_LEDS);
    localparam logic [PW-1:0] LAST_IDX = PW'(NUM_LEDS - 1);
    localparam logic [7:0]    STEP_Q   = 8'(256 / NUM_LEDS);
    localparam logic [PW:0]   STEP_R   = (PW + 1)'(256 % NUM_LEDS);
    localparam logic [PW:0]   TLEN     = (PW + 1)'(TRAIL_LEN);

    typedef logic [7:0] t_lut [16];

    function automatic t_lut f_trail_lut();
        t_lut lut;
        for (int t = 0; t < 16; t++) begin
            lut[t] = (t < TRAIL_LEN) ? 8'((255 * (TRAIL_LEN - t)) / TRAIL_LEN) : 8'd0;
        end
        return lut;
    endfunction

    localparam t_lut TRAIL_LUT = f_trail_lut();
    localparam t_lut WAVE_LUT  = '{
        8'd127, 8'd176, 8'd217, 8'd245, 8'd255, 8'd245, 8'd217, 8'd176,
        8'd127, 8'd78,  8'd37,  8'd9,   8'd0,   8'd9,   8'd37,  8'd78
    };

    function automatic logic [23:0] f_wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [9:0] q3;
        logic [23:0] c;
        p = 8'd255 - pos;
        if (p < 8'd85) begin
            q = p;
        end else if (p < 8'd170) begin
            q = p - 8'd85;
        end else begin
            q = p - 8'd170;
        end
        q3 = {2'b00, q} * 10'd3;
        if (p < 8'd85) begin
            c = {8'd255 - q3[7:0], 8'd0, q3[7:0]};
        end else if (p < 8'd170) begin
            c = {8'd0, q3[7:0], 8'd255 - q3[7:0]};
        end else begin
            c = {q3[7:0], 8'd255 - q3[7:0], 8'd0};
        end
        return c;
    endfunction

    logic [PW-1:0] r_pix;
    logic [7:0]    r_rq, n_rq;
    logic [PW:0]   r_rr, n_rr;

    logic          en;
    logic          issue;
    logic          last;
    logic [PW:0]   rr_sum;
    logic          rr_wrap;
    logic [PW:0]   t1_sum, t1;
    logic [PW:0]   t2_sum, t2;

    logic                         r_s1_valid;
    lsafg_pkg::t_mode             r_s1_mode;
    logic [PW-1:0]                r_s1_index;
    logic                         r_s1_last;
    logic [lsafg_pkg::HOLD_W-1:0] r_s1_hold;
    logic [7:0]                   r_s1_pos;
    logic [3:0]                   r_s1_wave;
    logic                         r_s1_t1_hit;
    logic [3:0]                   r_s1_t1;
    logic                         r_s1_t2_hit;
    logic [3:0]                   r_s1_t2;
    logic                         r_s1_alarm_on;
    logic [PRW-1:0]               r_s1_prod_r, r_s1_prod_g, r_s1_prod_b;

    logic                         r_s2_valid;
    logic [PW-1:0]                r_s2_index;
    logic [lsafg_pkg::COLOR_W-1:0] r_s2_color, n_s2_color;
    logic                         r_s2_last;
    logic [lsafg_pkg::HOLD_W-1:0] r_s2_hold;
    logic [7:0]                   trail_b;

    assign en    = !r_s2_valid || !i_stall;
    assign issue = en && i_cmd_valid;
    assign last  = (r_pix == LAST_IDX);
    assign o_pop = issue && last;

    // running i * 256 / n as quotient and remainder
    assign rr_sum  = r_rr + STEP_R;
    assign rr_wrap = (rr_sum >= N7);
    assign n_rr    = rr_wrap ? rr_sum - N7 : rr_sum;
    assign n_rq    = r_rq + STEP_Q + {7'd0, rr_wrap};

    assign t1_sum = {1'b0, i_cmd.head_cw} + N7 - {1'b0, r_pix};
    assign t1     = (t1_sum >= N7) ? t1_sum - N7 : t1_sum;
    assign t2_sum = {1'b0, r_pix} + N7 - {1'b0, i_cmd.head_ccw};
    assign t2     = (t2_sum >= N7) ? t2_sum - N7 : t2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
            r_rq  <= '0;
            r_rr  <= '0;
        end else if (issue) begin
            if (last) begin
                r_pix <= '0;
                r_rq  <= '0;
                r_rr  <= '0;
            end else begin
                r_pix <= r_pix + PW'(1);
                r_rq  <= n_rq;
                r_rr  <= n_rr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_mode     <= i_cmd.mode;
            r_s1_index    <= r_pix;
            r_s1_last     <= last;
            r_s1_hold     <= last ? i_cmd.hold : '0;
            r_s1_pos      <= r_rq + i_cmd.rainbow_offset;
            r_s1_wave     <= r_pix[3:0] + i_cmd.wave_step[3:0];
            r_s1_t1_hit   <= (t1 < TLEN);
            r_s1_t1       <= t1[3:0];
            r_s1_t2_hit   <= (t2 < TLEN);
            r_s1_t2       <= t2[3:0];
            r_s1_alarm_on <= i_cmd.alarm_phase[0];
            r_s1_prod_r   <= {{(PRW-8){1'b0}}, i_cmd.color[23:16]}
                           * {8'd0, i_cmd.breathe_k};
            r_s1_prod_g   <= {{(PRW-8){1'b0}}, i_cmd.color[15:8]}
                           * {8'd0, i_cmd.breathe_k};
            r_s1_prod_b   <= {{(PRW-8){1'b0}}, i_cmd.color[7:0]}
                           * {8'd0, i_cmd.breathe_k};
        end
    end

    always_comb begin
        trail_b = 8'd0;
        if (r_s1_t1_hit) begin
            trail_b = TRAIL_LUT[r_s1_t1];
        end
        if (r_s1_t2_hit) begin
            trail_b = TRAIL_LUT[r_s1_t2];
        end
    end

    always_comb begin
        unique case (r_s1_mode)
            lsafg_pkg::MODE_RAINBOW: n_s2_color = f_wheel(r_s1_pos);
            lsafg_pkg::MODE_BREATHE: n_s2_color = {r_s1_prod_r[23:16], r_s1_prod_g[23:16],
                                                   r_s1_prod_b[23:16]};
            lsafg_pkg::MODE_WAVE:    n_s2_color = {16'd0, WAVE_LUT[r_s1_wave]};
            lsafg_pkg::MODE_TRAILS:  n_s2_color = {16'd0, trail_b};
            lsafg_pkg::MODE_ALARM:   n_s2_color = r_s1_alarm_on ? lsafg_pkg::COLOR_GREEN
                                                                : 24'd0;
            lsafg_pkg::MODE_GREEN:   n_s2_color = lsafg_pkg::COLOR_GREEN;
            lsafg_pkg::MODE_RED:     n_s2_color = lsafg_pkg::COLOR_RED;
            lsafg_pkg::MODE_BLUE:    n_s2_color = lsafg_pkg::COLOR_BLUE;
            default:                 n_s2_color = 24'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_s2_index <= r_s1_index;
            r_s2_color <= n_s2_color;
            r_s2_last  <= r_s1_last;
            r_s2_hold  <= r_s1_hold;
        end
    end

    assign o_valid       = r_s2_valid;
    assign o_pixel_index = r_s2_index;
    assign o_pixel_color = r_s2_color;
    assign o_frame_last  = r_s2_last;
    assign o_hold_ms     = r_s2_hold;

    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix <= LAST_IDX)
        else $error("pixel counter beyond strip length");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_last) |-> (r_s2_index == LAST_IDX))
        else $error("frame end flagged on wrong pixel");

    a_hold_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_last) |-> (r_s2_hold == '0))
        else $error("hold time on a pixel that is not last");

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pix == '0))
        else $error("pixel counter not restarted after frame");

endmodule

`default_nettype wire

FILE: rtl/core/led_strip_animation_frame_generator_top.sv
// Each accepted request produces one frame of NUM_LEDS pixel results, one per cycle in strip
// order while i_stall is low, the last one flagged and carrying the hold time. The first pixel
// passes the command queue and both back-end stage registers. The front end accepts a request
// in any cycle the two-entry command queue has room, so consecutive frames stream with no gap.
// The user must write mode and breathe colour only while idle; the block does not enforce it.
// top level: instantiates lsafg_front, lsafg_cmd_queue and lsafg_back; depends on lsafg_pkg
`default_nettype none

module led_strip_animation_frame_generator_top #(
    parameter int NUM_LEDS  = lsafg_pkg::NUM_LEDS_DEF,
    parameter int TRAIL_LEN = lsafg_pkg::TRAIL_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          i_advance,
    output logic                               o_stall,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [lsafg_pkg::COLOR_W-1:0] i_cfg_data,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [lsafg_pkg::PIX_W-1:0]        o_pixel_index,
    output logic [lsafg_pkg::COLOR_W-1:0]      o_pixel_color,
    output logic                               o_frame_last,
    output logic [lsafg_pkg::HOLD_W-1:0]       o_hold_ms
);

    logic                  push;
    logic                  full;
    logic                  q_valid;
    logic                  pop;
    lsafg_pkg::t_frame_cmd front_cmd;
    lsafg_pkg::t_frame_cmd head_cmd;

    lsafg_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_advance   (i_advance),
        .o_stall     (o_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .i_full      (full)
    );

    lsafg_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    lsafg_back #(
        .NUM_LEDS  (NUM_LEDS),
        .TRAIL_LEN (TRAIL_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_index (o_pixel_index),
        .o_pixel_color (o_pixel_color),
        .o_frame_last  (o_frame_last),
        .o_hold_ms     (o_hold_ms)
    );

endmodule

`default_nettype wire
